/* hdl/plist_pkg.sv */
package plist_pkg;

  // Opcodes of an input item
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRAVERSE = 2'd2,
    OP_IGNORE   = 2'd3
  } opcode_e;

  // Status codes of a result item
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int unsigned PosWidth  = 6;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned LenWidth  = 6;

  // Per-cell control for one cycle
  typedef struct packed {
    logic load;        // take the inserted word
    logic from_left;   // take the word of the cell one position nearer the head
    logic from_right;  // take the word of the cell one position nearer the tail
    logic sel;         // drive the read tap
  } cell_ctl_t;

endpackage

/* hdl/plist_cell.sv */
module plist_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  plist_pkg::cell_ctl_t  ctl_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] tap_o
);
  import plist_pkg::*;

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.load) begin
      data_d = word_i;
    end else if (ctl_i.from_left) begin
      data_d = left_i;
    end else if (ctl_i.from_right) begin
      data_d = right_i;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tap_o  = ctl_i.sel ? data_q : '0;

endmodule

/* hdl/positional_list_insert_delete.sv */
// Bounded positional list built as a row of CAPACITY shift cells; cell k holds
// list position k+1. An insert at position p loads cell p-1 and moves every
// later cell one step toward the tail; a delete at p returns cell p-1 and moves
// every later cell one step toward the head. Both finish in the cycle the item
// is accepted, so insert, delete, error and ignored items each give one result
// with last set. A traverse gives one result per entry, tail first, one per
// cycle unless the output stalls, from a read tap on the row (a single result
// for an empty list); the input is stalled until its final result is loaded.
// The result register can hold one finished item while the output is stalled;
// a new item is taken when no traverse runs and that register is empty or
// being emptied. Insert into a full list reports status full before any
// position check; a position of zero or past the end reports status range and
// leaves the list as it was. Stored words keep DATA_WIDTH bits; the low CW bits
// cross the ports, zero-extended on output. Cell contents have no reset; only
// positions below the current length are ever read.
module positional_list_insert_delete #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      opcode_i,
  input  logic [plist_pkg::PosWidth-1:0]  position_i,
  input  logic [plist_pkg::WordWidth-1:0] item_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [plist_pkg::WordWidth-1:0] out_data_o,
  output logic [plist_pkg::LenWidth-1:0]  list_length_o,
  output logic                            last_o
);
  import plist_pkg::*;

  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CNTW = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((CNTW > PosWidth) ? CNTW : PosWidth) + 1;
  // bits of a word that cross the fixed-width ports
  localparam int unsigned CW   = (DATA_WIDTH < WordWidth) ? DATA_WIDTH : WordWidth;

  typedef enum logic {
    S_IDLE,
    S_TRAV
  } state_e;

  state_e                state_q, state_d;
  logic [CNTW-1:0]       count_q, count_d;
  logic [IW-1:0]         rd_idx_q, rd_idx_d;
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            status_q, status_d;
  logic [WordWidth-1:0]  out_data_q, out_data_d;
  logic [LenWidth-1:0]   length_q, length_d;
  logic                  last_q, last_d;

  logic                  out_free;
  logic                  in_acc;
  logic                  ins_en;
  logic                  del_en;
  logic [CMPW-1:0]       pos_x;
  logic [CMPW-1:0]       cnt_x;
  logic [CMPW-1:0]       pidx;
  logic [IW-1:0]         rd_sel;
  logic [DATA_WIDTH-1:0] word_in;
  logic [DATA_WIDTH-1:0] tap_data;
  logic [DATA_WIDTH-1:0] res_word;

  cell_ctl_t             ctl    [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_w [CAPACITY];
  logic [DATA_WIDTH-1:0] tap_w  [CAPACITY];

  // Handshake: the result register must be free to take a new item
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pos_x = CMPW'(position_i);
  assign cnt_x = CMPW'(count_q);
  assign pidx  = pos_x - CMPW'(1);

  always_comb begin
    word_in         = '0;
    word_in[CW-1:0] = item_data_i[CW-1:0];
  end

  // Read tap: delete reads its position, a traverse starts at the tail
  always_comb begin
    if (state_q == S_TRAV) begin
      rd_sel = rd_idx_q;
    end else if (opcode_i == OP_DELETE) begin
      rd_sel = pidx[IW-1:0];
    end else begin
      rd_sel = IW'(count_q - CNTW'(1));
    end
  end

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (i == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_w[i+1];
    end

    assign ctl[i].load       = ins_en && (pidx == CMPW'(i));
    assign ctl[i].from_left  = ins_en && (pidx < CMPW'(i));
    assign ctl[i].from_right = del_en && (pidx <= CMPW'(i));
    assign ctl[i].sel        = (rd_sel == IW'(i));

    plist_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl[i]),
      .word_i (word_in),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (cell_w[i]),
      .tap_o  (tap_w[i])
    );
  end

  // At most one cell drives its tap
  always_comb begin
    tap_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      tap_data = tap_data | tap_w[k];
    end
  end

  // Next-state and result logic
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    out_data_d  = out_data_q;
    length_d    = length_q;
    last_d      = last_q;
    ins_en      = 1'b0;
    del_en      = 1'b0;
    res_word    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          last_d      = 1'b1;
          case (opcode_i)
            OP_INSERT: begin
              if (cnt_x == CMPW'(CAPACITY)) begin
                status_d = ST_FULL;
              end else if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
                status_d = ST_RANGE;
              end else begin
                ins_en  = 1'b1;
                count_d = count_q + CNTW'(1);
              end
            end
            OP_DELETE: begin
              if (pos_x == '0 || pos_x > cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                del_en   = 1'b1;
                res_word = tap_data;
                count_d  = count_q - CNTW'(1);
              end
            end
            OP_TRAVERSE: begin
              if (count_q != '0) begin
                res_word = tap_data;
                if (count_q != CNTW'(1)) begin
                  last_d   = 1'b0;
                  rd_idx_d = IW'(count_q - CNTW'(2));
                  state_d  = S_TRAV;
                end
              end
            end
            default: begin
            end
          endcase
          length_d = LenWidth'(count_d);
        end
      end
      S_TRAV: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          res_word    = tap_data;
          length_d    = LenWidth'(count_q);
          last_d      = (rd_idx_q == '0);
          rd_idx_d    = rd_idx_q - IW'(1);
          if (rd_idx_q == '0) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (out_valid_d && !(out_valid_q && out_stall_i)) begin
      out_data_d         = '0;
      out_data_d[CW-1:0] = res_word[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      out_data_q  <= '0;
      length_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      out_data_q  <= out_data_d;
      length_q    <= length_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_data_o    = out_data_q;
  assign list_length_o = length_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CAPACITY))
    else $error("entry count above capacity");

  a_trav_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TRAV |-> count_q != '0 && CNTW'(rd_idx_q) < count_q)
    else $error("traverse index outside the list");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_en |=> count_q == $past(count_q) + CNTW'(1))
    else $error("insert did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    del_en |=> count_q == $past(count_q) - CNTW'(1))
    else $error("delete did not shrink the list");

  a_trav_holds_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TRAV |=> $stable(count_q))
    else $error("list changed during traverse");
`endif

endmodule
